@@ rtl/core/wpsw_pkg.sv @@
// Shared types and constants of the WAV PCM stream writer.
package wpsw_pkg;

	// Input command codes (bit 0 of the slave-side tuser).
	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_WIDTH_SEL = 2'd0;
	localparam logic [1:0] REG_CHANNELS  = 2'd1;
	localparam logic [1:0] REG_RATE      = 2'd2;
	localparam logic [1:0] REG_FRAMES    = 2'd3;

	// Kind of job handed from the front to the back.
	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_REFUSE = 2'd2;

	localparam int HDR_LEN   = 44;
	localparam int HDR_IDX_W = 6;

	// Chunk tags as little-endian words, first character in the low byte.
	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	localparam logic [31:0] HDR_BASE = 32'd36;
	// Largest data size that still leaves room for the 36 header bytes.
	localparam logic [31:0] DATA_MAX = 32'hFFFF_FFDB;

	typedef struct packed {
		logic        wide;
		logic [4:0]  chans;
		logic [31:0] rate;
		logic [31:0] frames;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        wide;
		logic [23:0] code;
		logic [4:0]  chans;
		logic [6:0]  bpf;
		logic [31:0] rate;
		logic [31:0] byte_rate;
		logic [31:0] riff_size;
		logic [31:0] data_size;
	} entry_t;

endpackage

@@ rtl/core/wav_pcm_stream_writer.sv @@
// A word reaches the output via the front stages, the queue, the job and output registers.
// One byte per cycle out while m_tready is high; a sample is 2 or 3 bytes, a header 44,
// a refusal 1. The byte-wide output register in the back end sets the sustained rate.
// Input words are taken one per cycle until the two-entry job queue and front stages fill.
// Reset (arst_n low) empties all stages and the queue and loads the register defaults:
// 16-bit samples, two channels, 48000 Hz, zero frames.
module wav_pcm_stream_writer #(
	parameter int MAX_CHANNELS     = 16,
	parameter int SAMPLE_FRAC_BITS = 30
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write port.
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_wdata,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_value
	input  logic [1:0]  s_tuser,   // [0] cmd, [1] not_finite
	// Output stream, one byte per word.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast,   // last_byte
	output logic        m_tuser    // [0] status
);

	wpsw_pkg::cfg_t   cfg_q;
	wpsw_pkg::entry_t front_entry;
	wpsw_pkg::entry_t back_entry;
	logic             front_valid;
	logic             front_ready;
	logic             back_valid;
	logic             back_ready;
	logic [$bits(wpsw_pkg::entry_t)-1:0] q_out;

	// The user must write the registers only while the block is idle, so every job in
	// flight sees the same settings; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wide   <= 1'b0;
			cfg_q.chans  <= 5'd2;
			cfg_q.rate   <= 32'd48000;
			cfg_q.frames <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				wpsw_pkg::REG_WIDTH_SEL: cfg_q.wide   <= cfg_wdata[0];
				wpsw_pkg::REG_CHANNELS:  cfg_q.chans  <= cfg_wdata[4:0];
				wpsw_pkg::REG_RATE:      cfg_q.rate   <= cfg_wdata;
				wpsw_pkg::REG_FRAMES:    cfg_q.frames <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The front converts samples and checks header limits in two stages.
	wpsw_front #(
		.MAX_CHANNELS     (MAX_CHANNELS),
		.SAMPLE_FRAC_BITS (SAMPLE_FRAC_BITS)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.in_valid      (s_tvalid),
		.in_ready      (s_tready),
		.in_cmd        (s_tuser[0]),
		.in_sample     (s_tdata),
		.in_not_finite (s_tuser[1]),
		.out_valid     (front_valid),
		.out_ready     (front_ready),
		.out_entry     (front_entry)
	);

	// The queue lets the front keep taking words while the back streams a header.
	wpsw_fifo #(
		.WIDTH ($bits(wpsw_pkg::entry_t)),
		.DEPTH (2)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_entry),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_data  (q_out)
	);

	assign back_entry = wpsw_pkg::entry_t'(q_out);

	// The back serializes each job onto the byte stream.
	wpsw_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_valid),
		.in_ready (back_ready),
		.in_entry (back_entry),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

@@ rtl/core/wpsw_front.sv @@
// Front end: accepts words, converts samples and builds header fields.
module wpsw_front #(
	parameter int MAX_CHANNELS     = 16,
	parameter int SAMPLE_FRAC_BITS = 30
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wpsw_pkg::cfg_t      cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_cmd,
	input  logic signed [31:0]  in_sample,
	input  logic                in_not_finite,
	output logic                out_valid,
	input  logic                out_ready,
	output wpsw_pkg::entry_t    out_entry
);

	localparam int MAG_W = SAMPLE_FRAC_BITS + 1;
	localparam int MW    = (MAG_W > 32) ? MAG_W : 32;
	localparam int SH16  = SAMPLE_FRAC_BITS - 15;
	localparam int SH24  = SAMPLE_FRAC_BITS - 23;
	localparam logic [MW-1:0]   ONE    = MW'(1) << SAMPLE_FRAC_BITS;
	localparam logic [SH16-1:0] HALF16 = SH16'(1) << (SH16 - 1);
	localparam logic [SH24-1:0] HALF24 = SH24'(1) << (SH24 - 1);

	// Stage 1: captured word and configuration.
	logic        valid_s1;
	logic        cmd_s1;
	logic [31:0] raw_s1;
	logic        nf_s1;
	logic        wide_s1;
	logic [4:0]  chans_s1;
	logic [6:0]  bpf_s1;
	logic [31:0] rate_s1;
	logic [31:0] frames_s1;

	// Stage 2: magnitude and products.
	logic             valid_s2;
	logic             cmd_s2;
	logic             neg_s2;
	logic [MAG_W-1:0] mag_s2;
	logic             wide_s2;
	logic [4:0]       chans_s2;
	logic [6:0]       bpf_s2;
	logic [31:0]      rate_s2;
	logic [38:0]      byte_rate_s2;
	logic [38:0]      data_s2;

	logic        adv2;
	logic        take;
	logic [6:0]  bpf_in;
	logic [31:0] mag32;
	logic [MW-1:0] mag_w;
	logic [MW-1:0] mag_c;

	logic [15:0]     q16;
	logic [SH16-1:0] r16;
	logic            inc16;
	logic [16:0]     qr16;
	logic [16:0]     qs16;
	logic [15:0]     code16;
	logic [23:0]     q24;
	logic [SH24-1:0] r24;
	logic            inc24;
	logic [24:0]     qr24;
	logic [24:0]     qs24;
	logic [23:0]     code24;
	logic            refuse;

	assign adv2     = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv2;
	assign take     = in_valid && in_ready;

	assign bpf_in = cfg.wide ? (7'({cfg.chans, 1'b0}) + 7'(cfg.chans))
	                         : 7'({cfg.chans, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1    <= in_cmd;
			raw_s1    <= in_sample;
			nf_s1     <= in_not_finite;
			wide_s1   <= cfg.wide;
			chans_s1  <= cfg.chans;
			bpf_s1    <= bpf_in;
			rate_s1   <= cfg.rate;
			frames_s1 <= cfg.frames;
		end
	end

	// A non-finite sample reads as zero; the most negative input has magnitude 2^31.
	assign mag32 = nf_s1 ? 32'd0 : (raw_s1[31] ? (~raw_s1 + 32'd1) : raw_s1);
	assign mag_w = MW'(mag32);
	assign mag_c = (mag_w > ONE) ? ONE : mag_w;

	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			cmd_s2       <= cmd_s1;
			neg_s2       <= raw_s1[31] && !nf_s1;
			mag_s2       <= mag_c[MAG_W-1:0];
			wide_s2      <= wide_s1;
			chans_s2     <= chans_s1;
			bpf_s2       <= bpf_s1;
			rate_s2      <= rate_s1;
			byte_rate_s2 <= 39'(rate_s1) * 39'(bpf_s1);
			data_s2      <= 39'(frames_s1) * 39'(bpf_s1);
		end
	end

	// Round half to even at each output width, then saturate to the PCM range.
	assign q16   = mag_s2[MAG_W-1:SH16];
	assign r16   = mag_s2[SH16-1:0];
	assign inc16 = (r16 > HALF16) || ((r16 == HALF16) && q16[0]);
	assign qr16  = {1'b0, q16} + 17'(inc16);
	assign q24   = mag_s2[MAG_W-1:SH24];
	assign r24   = mag_s2[SH24-1:0];
	assign inc24 = (r24 > HALF24) || ((r24 == HALF24) && q24[0]);
	assign qr24  = {1'b0, q24} + 25'(inc24);

	always_comb begin
		if (neg_s2) begin
			qs16 = (qr16 > 17'h0_8000) ? 17'h0_8000 : qr16;
			qs24 = (qr24 > 25'h080_0000) ? 25'h080_0000 : qr24;
		end else begin
			qs16 = (qr16 > 17'h0_7FFF) ? 17'h0_7FFF : qr16;
			qs24 = (qr24 > 25'h07F_FFFF) ? 25'h07F_FFFF : qr24;
		end
		code16 = neg_s2 ? 16'(17'd0 - qs16) : qs16[15:0];
		code24 = neg_s2 ? 24'(25'd0 - qs24) : qs24[23:0];
	end

	assign refuse = (chans_s2 == 5'd0) || ({27'd0, chans_s2} > 32'(MAX_CHANNELS)) ||
	                (rate_s2 == 32'd0) || (byte_rate_s2[38:32] != 7'd0) ||
	                (data_s2 > 39'(wpsw_pkg::DATA_MAX));

	always_comb begin
		out_entry.wide      = wide_s2;
		out_entry.code      = wide_s2 ? code24 : {8'd0, code16};
		out_entry.chans     = chans_s2;
		out_entry.bpf       = bpf_s2;
		out_entry.rate      = rate_s2;
		out_entry.byte_rate = byte_rate_s2[31:0];
		out_entry.data_size = data_s2[31:0];
		out_entry.riff_size = data_s2[31:0] + wpsw_pkg::HDR_BASE;
		if (cmd_s2 == wpsw_pkg::CMD_SAMPLE) begin
			out_entry.kind = wpsw_pkg::KIND_SAMPLE;
		end else if (refuse) begin
			out_entry.kind = wpsw_pkg::KIND_REFUSE;
		end else begin
			out_entry.kind = wpsw_pkg::KIND_HEADER;
		end
	end

	assign out_valid = valid_s2;

endmodule

@@ rtl/core/wpsw_fifo.sv @@
// Small register queue between the front and the back.
module wpsw_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [AW:0]      count_q;
	logic             push;
	logic             pop;

	assign in_ready  = count_q != (AW + 1)'(DEPTH);
	assign out_valid = count_q != '0;
	assign out_data  = mem_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) begin
				count_q <= count_q + (AW + 1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (AW + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_data;
	end

endmodule

@@ rtl/core/wpsw_back.sv @@
// Back end: walks each queued job out one byte per word on the output stream.
module wpsw_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  wpsw_pkg::entry_t in_entry,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast,
	output logic             m_tuser
);

	logic                          cur_valid_q;
	wpsw_pkg::entry_t              cur_q;
	logic [wpsw_pkg::HDR_IDX_W-1:0] idx_q;
	logic                          m_tvalid_q;
	logic [7:0]                    m_tdata_q;
	logic                          m_tlast_q;
	logic                          m_tuser_q;

	logic [wpsw_pkg::HDR_LEN-1:0][7:0] hdr;
	logic [7:0] bits;
	logic [7:0] byte_nxt;
	logic       is_last;
	logic       load;

	assign bits = cur_q.wide ? 8'd24 : 8'd16;

	// Header image, byte 0 in the low bits.
	assign hdr = {cur_q.data_size, wpsw_pkg::TAG_DATA,
	              8'h00, bits, 8'h00, {1'b0, cur_q.bpf},
	              cur_q.byte_rate, cur_q.rate,
	              8'h00, {3'b000, cur_q.chans}, 16'h0001, 32'd16,
	              wpsw_pkg::TAG_FMT, wpsw_pkg::TAG_WAVE,
	              cur_q.riff_size, wpsw_pkg::TAG_RIFF};

	always_comb begin
		case (cur_q.kind)
			wpsw_pkg::KIND_SAMPLE: begin
				is_last = idx_q == (cur_q.wide ? wpsw_pkg::HDR_IDX_W'(2)
				                               : wpsw_pkg::HDR_IDX_W'(1));
				case (idx_q[1:0])
					2'd0:    byte_nxt = cur_q.code[7:0];
					2'd1:    byte_nxt = cur_q.code[15:8];
					default: byte_nxt = cur_q.code[23:16];
				endcase
			end
			wpsw_pkg::KIND_HEADER: begin
				is_last  = idx_q == wpsw_pkg::HDR_IDX_W'(wpsw_pkg::HDR_LEN - 1);
				byte_nxt = hdr[idx_q];
			end
			default: begin
				is_last  = 1'b1;
				byte_nxt = 8'h00;
			end
		endcase
	end

	assign load     = cur_valid_q && (!m_tvalid_q || m_tready);
	assign in_ready = !cur_valid_q || (load && is_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				cur_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (load && is_last) begin
				cur_valid_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + wpsw_pkg::HDR_IDX_W'(1);
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) cur_q <= in_entry;
		if (load) begin
			m_tdata_q <= byte_nxt;
			m_tlast_q <= is_last;
			m_tuser_q <= cur_q.kind == wpsw_pkg::KIND_REFUSE;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

endmodule
